// File: rtl/tidst_pkg.sv
// ----------------------------------------------------------------------------
// Tracked id state table package
// Shared types, opcodes, status codes and helpers for the tracked id table.
// ----------------------------------------------------------------------------
`default_nettype none

package tidst_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int STATE_BITS_DEF  = 3;

  // Value that marks the current id or the last tracked id as unset.
  localparam logic signed [31:0] ID_NONE = -32'sd1;

  // Operation codes.
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_GET     = 3'd2;
  localparam logic [2:0] OP_ADVANCE = 3'd3;
  localparam logic [2:0] OP_CLR_BAD = 3'd4;
  localparam logic [2:0] OP_CLR_ALL = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ABOVE = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_MISSING   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BACKWARDS = 3'd5;

  // One request.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [30:0] entry_id;
    logic [2:0]  entry_state;
  } in_t;

  // One result.
  typedef struct packed {
    logic               ok;
    logic [2:0]         status;
    logic [2:0]         read_state;
    logic signed [31:0] current_id;
    logic [2:0]         current_state;
    logic signed [31:0] last_tracked;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and clear the scan results
    logic issue;   // read the next table slot
    logic commit;  // apply the operation and present the result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;   // the request on the input needs a table scan
    logic issue_last;  // the slot being read is the last one
  } dp_sts_t;

  // A state code is bad when its bit in the mask is set.
  function automatic logic is_bad(input logic [7:0] mask, input logic [2:0] code);
    return mask[code];
  endfunction

endpackage

`default_nettype wire

// File: rtl/tidst_ctrl.sv
// ----------------------------------------------------------------------------
// Tracked id table controller
// Sequences request capture, the slot scan and the final commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tidst_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire tidst_pkg::dp_sts_t  sts,
  output logic                     busy,
  output tidst_pkg::ctl_cmd_t      cmd
);
  import tidst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.need_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot read is evaluated in this cycle.
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/tidst_dp.sv
// ----------------------------------------------------------------------------
// Tracked id table datapath
// Holds the slot table, the tracking registers and the scan logic that finds
// the addressed id, the lowest free slot and the lowest non-bad entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tidst_dp #(
  parameter int TABLE_DEPTH = tidst_pkg::TABLE_DEPTH_DEF,
  parameter int STATE_BITS  = tidst_pkg::STATE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tidst_pkg::in_t      in_data,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire tidst_pkg::ctl_cmd_t cmd,
  output tidst_pkg::dp_sts_t       sts,
  output logic                     out_valid,
  output tidst_pkg::out_t          out_data
);
  import tidst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // Configuration and captured request.
  logic [7:0]            mask_r;
  logic [2:0]            op_r;
  logic [30:0]           id_r;
  logic [STATE_BITS-1:0] st_r;

  // Slot table: valid bits in flops, ids and states in memory.
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [30:0]            mem_id [TABLE_DEPTH];
  logic [STATE_BITS-1:0]  mem_st [TABLE_DEPTH];

  // Scan pipeline.
  logic [IDX_W-1:0]      addr_r;
  logic [IDX_W-1:0]      idx_d_r;
  logic                  dvld_r;
  logic [30:0]           rd_id_r;
  logic [STATE_BITS-1:0] rd_st_r;

  // Scan results.
  logic                  match_r;
  logic [IDX_W-1:0]      match_idx_r;
  logic [STATE_BITS-1:0] match_st_r;
  logic                  free_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  best_r;
  logic [30:0]           best_id_r;
  logic [STATE_BITS-1:0] best_st_r;

  // Tracking registers.
  logic signed [31:0]    cur_id_r, cur_id_nxt;
  logic [STATE_BITS-1:0] cur_st_r, cur_st_nxt;
  logic signed [31:0]    last_r, last_nxt;

  // Result register.
  logic out_valid_r;
  out_t out_r;

  // Scan and commit signals.
  logic                  slot_vld;
  logic                  hit;
  logic [STATE_BITS-1:0] cand_st;
  logic                  better;
  logic                  kill;
  logic signed [31:0]    id_s;
  logic                  ok;
  logic [2:0]            status;
  logic [2:0]            rd_state;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic                  set_valid;
  logic                  clr_all;

  // Status towards the controller.
  always_comb begin
    case (in_data.opcode)
      OP_ADD, OP_SET, OP_GET: sts.need_scan = 1'b1;
      OP_CLR_BAD:             sts.need_scan = (mask_r != 8'd0);
      default:                sts.need_scan = 1'b0;
    endcase
    sts.issue_last = (addr_r == IDX_W'(TABLE_DEPTH - 1));
  end

  // Bad state mask register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'd0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data.opcode;
      id_r <= in_data.entry_id;
      st_r <= in_data.entry_state[STATE_BITS-1:0];
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_idx] <= id_r;
      mem_st[wr_idx] <= st_r;
    end
    if (cmd.issue) begin
      rd_id_r <= mem_id[addr_r];
      rd_st_r <= mem_st[addr_r];
    end
  end

  // Read address counter and data-valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      dvld_r <= 1'b0;
    end else begin
      dvld_r <= cmd.issue;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.issue) begin
        addr_r <= sts.issue_last ? '0 : addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      idx_d_r <= addr_r;
    end
  end

  // Evaluation of one slot. For a set the matching slot is taken with its
  // new state, so the lowest non-bad entry already reflects the write.
  assign slot_vld = valid_r[idx_d_r];
  assign hit      = slot_vld && (rd_id_r == id_r);
  assign cand_st  = ((op_r == OP_SET) && hit) ? st_r : rd_st_r;
  assign better   = slot_vld && !is_bad(mask_r, 3'(cand_st)) &&
                    (!best_r || (rd_id_r < best_id_r));
  assign kill     = slot_vld && (op_r == OP_CLR_BAD) && is_bad(mask_r, 3'(rd_st_r));

  // Scan result trackers, cleared when a request is captured.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_r <= 1'b0;
      free_r  <= 1'b0;
      best_r  <= 1'b0;
    end else if (dvld_r) begin
      if (hit) begin
        match_r     <= 1'b1;
        match_idx_r <= idx_d_r;
        match_st_r  <= rd_st_r;
      end
      if (!slot_vld && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_d_r;
      end
      if (better) begin
        best_r    <= 1'b1;
        best_id_r <= rd_id_r;
        best_st_r <= cand_st;
      end
    end
  end

  assign id_s = {1'b0, id_r};

  // Outcome of the operation and the next tracking values.
  always_comb begin
    ok         = 1'b0;
    status     = ST_OK;
    rd_state   = 3'd0;
    cur_id_nxt = cur_id_r;
    cur_st_nxt = cur_st_r;
    last_nxt   = last_r;
    wr_en      = 1'b0;
    wr_idx     = match_idx_r;
    set_valid  = 1'b0;
    clr_all    = 1'b0;
    case (op_r)
      OP_ADD: begin
        if (id_s <= last_r) begin
          status = ST_NOT_ABOVE;
        end else if (match_r) begin
          status = ST_EXISTS;
        end else if (!free_r) begin
          status = ST_FULL;
        end else begin
          ok        = 1'b1;
          wr_en     = cmd.commit;
          wr_idx    = free_idx_r;
          set_valid = 1'b1;
          if (!is_bad(mask_r, 3'(st_r)) && (!best_r || (id_r < best_id_r))) begin
            cur_id_nxt = id_s;
            cur_st_nxt = st_r;
          end else if (best_r) begin
            cur_id_nxt = {1'b0, best_id_r};
            cur_st_nxt = best_st_r;
          end else begin
            cur_id_nxt = ID_NONE;
            cur_st_nxt = '0;
          end
        end
      end
      OP_SET: begin
        if (!match_r) begin
          status = ST_MISSING;
        end else begin
          ok    = 1'b1;
          wr_en = cmd.commit;
          if (best_r) begin
            cur_id_nxt = {1'b0, best_id_r};
            cur_st_nxt = best_st_r;
          end else begin
            cur_id_nxt = ID_NONE;
            cur_st_nxt = '0;
          end
        end
      end
      OP_GET: begin
        if (!match_r) begin
          status = ST_MISSING;
        end else begin
          ok       = 1'b1;
          rd_state = 3'(match_st_r);
        end
      end
      OP_ADVANCE: begin
        // An unset last tracked id is below every id, so no special case.
        if (id_s < last_r) begin
          status = ST_BACKWARDS;
        end else begin
          ok       = 1'b1;
          last_nxt = id_s;
        end
      end
      OP_CLR_BAD: begin
        ok = 1'b1;
        if (mask_r != 8'd0) begin
          cur_id_nxt = ID_NONE;
          cur_st_nxt = '0;
          last_nxt   = ID_NONE;
        end
      end
      OP_CLR_ALL: begin
        ok         = 1'b1;
        clr_all    = 1'b1;
        cur_id_nxt = ID_NONE;
        cur_st_nxt = '0;
        last_nxt   = ID_NONE;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Valid bits: cleared by clear-all, set by an add, dropped by clear-bad.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && clr_all) begin
      valid_r <= '0;
    end else if (cmd.commit && set_valid) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (dvld_r && kill) begin
      valid_r[idx_d_r] <= 1'b0;
    end
  end

  // Tracking registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_id_r <= ID_NONE;
      cur_st_r <= '0;
      last_r   <= ID_NONE;
    end else if (cmd.commit) begin
      cur_id_r <= cur_id_nxt;
      cur_st_r <= cur_st_nxt;
      last_r   <= last_nxt;
    end
  end

  // Result strobe and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.ok            <= ok;
      out_r.status        <= status;
      out_r.read_state    <= rd_state;
      out_r.current_id    <= cur_id_nxt;
      out_r.current_state <= 3'(cur_st_nxt);
      out_r.last_tracked  <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/tracked_id_state_table_top.sv
// ----------------------------------------------------------------------------
// Tracked id state table
// Table of object ids with state codes, a last tracked id and a current entry.
// ----------------------------------------------------------------------------
// Add, set, get and clear-bad (with a non-empty mask) scan every slot of the
// table before they commit; one slot of the table memory is read per cycle.
// Other requests skip the scan and go from capture straight to the commit.
// A new request is taken in the cycle its predecessor's result is shown.
// The receiver cannot stall. Reset is synchronous: empty table, unset ids.
`default_nettype none

module tracked_id_state_table_top #(
  parameter int TABLE_DEPTH = tidst_pkg::TABLE_DEPTH_DEF,
  parameter int STATE_BITS  = tidst_pkg::STATE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tidst_pkg::in_t in_data,
  output logic                out_valid,
  output tidst_pkg::out_t     out_data,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_wdata
);
  import tidst_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer.
  tidst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Table and tracking datapath.
  tidst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A taken request keeps the block busy in the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // A result is only shown once the block is free again.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A successful request always reports the ok status.
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ok) |-> (out_data.status == ST_OK))
    else $error("success with error status");

  // With no current entry the current state reads as zero.
  a_none_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.current_id == ID_NONE)) |-> (out_data.current_state == 3'd0))
    else $error("current state set without current entry");

endmodule

`default_nettype wire

// File: test/tb_tracked_id_state_table_top.sv
// ----------------------------------------------------------------------------
// Tracked id state table testbench
// Drives add, set, get, advance, clear-bad and clear-all requests into the
// table, predicts every result in step with the requests taken, and compares
// each strobed result field by field. A short table of directed requests is
// followed by random episodes under several bad-state masks and idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tracked_id_state_table_top;
  import tidst_pkg::*;

  localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 300;
  localparam longint ID_MAX     = 64'h7FFF_FFFF;

  // Opcodes the block treats as no operation.
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // One row of the directed table: either a mask write or a request, with an
  // optional hand-written expected result.
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] mask;
    in_t        req;
    logic       typed;
    out_t       exp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  // Predicted table contents and tracking registers.
  logic               tbl_valid [TABLE_DEPTH];
  logic [30:0]        tbl_id    [TABLE_DEPTH];
  logic [2:0]         tbl_state [TABLE_DEPTH];
  logic signed [31:0] cur_id;
  logic [2:0]         cur_state;
  logic signed [31:0] last_id;
  logic [7:0]         bad_mask;

  out_t     expected_results [$];
  dir_row_t dir_table [$];
  int       mismatches;
  int       idle_cycles;

  tracked_id_state_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Slot holding the given id, or -1 when it is absent.
  function automatic int find_id(input logic [30:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // The current entry is the lowest id whose state is not bad.
  function automatic void recompute_current();
    bit found;
    found = 1'b0;
    cur_id = ID_NONE;
    cur_state = 3'd0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && !bad_mask[tbl_state[i]] &&
          (!found || tbl_id[i] < cur_id[30:0])) begin
        cur_id = {1'b0, tbl_id[i]};
        cur_state = tbl_state[i];
        found = 1'b1;
      end
    end
  endfunction

  function automatic void reset_tracking();
    cur_id = ID_NONE;
    cur_state = 3'd0;
    last_id = ID_NONE;
  endfunction

  // Applies one request to the predicted table and returns its result.
  function automatic out_t track_table_apply(input in_t req);
    out_t res;
    int   slot;
    res = '0;
    res.status = ST_OK;
    case (req.opcode)
      OP_ADD: begin
        if (longint'(req.entry_id) <= longint'(last_id)) begin
          res.status = ST_NOT_ABOVE;
        end else if (find_id(req.entry_id) >= 0) begin
          res.status = ST_EXISTS;
        end else begin
          slot = -1;
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
          end
          if (slot < 0) begin
            res.status = ST_FULL;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_id[slot] = req.entry_id;
            tbl_state[slot] = req.entry_state;
            recompute_current();
            res.ok = 1'b1;
          end
        end
      end
      OP_SET: begin
        slot = find_id(req.entry_id);
        if (slot < 0) begin
          res.status = ST_MISSING;
        end else begin
          tbl_state[slot] = req.entry_state;
          recompute_current();
          res.ok = 1'b1;
        end
      end
      OP_GET: begin
        slot = find_id(req.entry_id);
        if (slot < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.read_state = tbl_state[slot];
          res.ok = 1'b1;
        end
      end
      OP_ADVANCE: begin
        if (last_id != ID_NONE && longint'(req.entry_id) < longint'(last_id)) begin
          res.status = ST_BACKWARDS;
        end else begin
          last_id = {1'b0, req.entry_id};
          res.ok = 1'b1;
        end
      end
      OP_CLR_BAD: begin
        // An empty mask leaves the table and the tracking untouched.
        if (bad_mask != 8'h00) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i] && bad_mask[tbl_state[i]]) tbl_valid[i] = 1'b0;
          end
          reset_tracking();
        end
        res.ok = 1'b1;
      end
      OP_CLR_ALL: begin
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        reset_tracking();
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.current_id = cur_id;
    res.current_state = cur_state;
    res.last_tracked = last_id;
    return res;
  endfunction

  // An id that is present in the table, or a random one when it is empty.
  function automatic logic [30:0] present_id();
    int s;
    s = $urandom_range(TABLE_DEPTH - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[(s + i) % TABLE_DEPTH]) return tbl_id[(s + i) % TABLE_DEPTH];
    end
    return 31'($urandom);
  endfunction

  // Draws one random request, mostly one that gets past the first checks.
  // Filling episodes lean heavily on add so that the table runs full.
  function automatic in_t draw_request(input bit filling);
    in_t    req;
    int     pick;
    int     r;
    longint base;
    longint id;
    req.entry_state = 3'($urandom_range(7));
    req.entry_id = 31'($urandom);
    base = (last_id == ID_NONE) ? 0 : longint'(last_id) + 1;
    r = $urandom_range(99);
    if (filling && $urandom_range(99) < 85) pick = 0;
    else pick = $urandom_range(99);
    if (pick < 35) begin
      req.opcode = OP_ADD;
      if (r < 10) begin
        id = longint'(req.entry_id);
      end else if (r < 18) begin
        id = longint'(present_id());
      end else if (r < 25) begin
        id = (last_id == ID_NONE) ? 0 : longint'(last_id);
      end else begin
        id = base + $urandom_range(40);
      end
      req.entry_id = 31'((id > ID_MAX) ? ID_MAX : id);
    end else if (pick < 70) begin
      req.opcode = (pick < 55) ? OP_SET : OP_GET;
      if (r < 75) req.entry_id = present_id();
      else if (r < 90) req.entry_id = 31'(base + $urandom_range(8));
    end else if (pick < 83) begin
      req.opcode = OP_ADVANCE;
      id = (last_id == ID_NONE) ? 0 : longint'(last_id);
      if (r < 75) id = id + $urandom_range(4);
      else if (r < 92) id = id - $urandom_range(1, 3);
      else id = longint'(req.entry_id);
      req.entry_id = 31'((id < 0) ? 0 : ((id > ID_MAX) ? ID_MAX : id));
    end else if (pick < 91) begin
      req.opcode = OP_CLR_BAD;
    end else if (pick < 94) begin
      req.opcode = OP_CLR_ALL;
    end else begin
      req.opcode = (r < 50) ? OP_UNUSED_LO : OP_UNUSED_HI;
    end
    return req;
  endfunction

  // Presents one request after a random idle gap and waits until it is taken.
  // Start stays high on return so that a following request goes back to back.
  task automatic send_request(input in_t req, input int idle_pct,
                              input logic typed, input out_t exp);
    out_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    predicted = track_table_apply(req);
    expected_results.push_back(typed ? exp : predicted);
  endtask

  // Writes the bad-state mask once every outstanding result has arrived.
  task automatic write_mask(input logic [7:0] mask);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    bad_mask = mask;
  endtask

  function automatic void check_field(input string name, input longint exp,
                                      input longint got, input bit differs);
    if (differs) begin
      $error("%s: expected %0d, got %0d", name, exp, got);
      mismatches++;
    end
  endfunction

  // Every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    out_t exp;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        exp = expected_results.pop_front();
        check_field("ok", exp.ok, out_data.ok, out_data.ok !== exp.ok);
        check_field("status", exp.status, out_data.status,
                    out_data.status !== exp.status);
        check_field("read_state", exp.read_state, out_data.read_state,
                    out_data.read_state !== exp.read_state);
        check_field("current_id", exp.current_id, out_data.current_id,
                    out_data.current_id !== exp.current_id);
        check_field("current_state", exp.current_state, out_data.current_state,
                    out_data.current_state !== exp.current_state);
        check_field("last_tracked", exp.last_tracked, out_data.last_tracked,
                    out_data.last_tracked !== exp.last_tracked);
      end
    end
  end

  // The run is stopped when nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int             sent;
    int             ep_len;
    bit             filling;
    int             phase_idle [6];
    logic [7:0]     phase_mask [6];

    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'h00;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_state[i] = '0;
    end
    reset_tracking();
    bad_mask = 8'h00;

    // Directed requests: empty table, the id extremes, every error code but full,
    // unused opcodes and clear-bad with an empty, a partial and a full mask.
    dir_table.push_back('{1'b0, 8'h00, '{OP_GET, 31'd5, 3'd0}, 1'b1,
                          '{1'b0, ST_MISSING, 3'd0, ID_NONE, 3'd0, ID_NONE}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_SET, 31'd5, 3'd3}, 1'b1,
                          '{1'b0, ST_MISSING, 3'd0, ID_NONE, 3'd0, ID_NONE}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADVANCE, 31'd0, 3'd0}, 1'b1,
                          '{1'b1, ST_OK, 3'd0, ID_NONE, 3'd0, 32'sd0}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADD, 31'd0, 3'd2}, 1'b1,
                          '{1'b0, ST_NOT_ABOVE, 3'd0, ID_NONE, 3'd0, 32'sd0}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADVANCE, 31'd0, 3'd1}, 1'b1,
                          '{1'b1, ST_OK, 3'd0, ID_NONE, 3'd0, 32'sd0}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADD, 31'h7FFF_FFFF, 3'd7}, 1'b1,
                          '{1'b1, ST_OK, 3'd0, 32'sh7FFF_FFFF, 3'd7, 32'sd0}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADD, 31'h7FFF_FFFF, 3'd1}, 1'b1,
                          '{1'b0, ST_EXISTS, 3'd0, 32'sh7FFF_FFFF, 3'd7, 32'sd0}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADD, 31'd1, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_GET, 31'h7FFF_FFFF, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_SET, 31'd1, 3'd5}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADVANCE, 31'd3, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADVANCE, 31'd2, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_CLR_BAD, 31'd0, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_UNUSED_LO, 31'd9, 3'd6}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_UNUSED_HI, 31'd9, 3'd7}, 1'b0, '0});
    dir_table.push_back('{1'b1, 8'h20, '0, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_SET, 31'd1, 3'd5}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_CLR_BAD, 31'd0, 3'd0}, 1'b1,
                          '{1'b1, ST_OK, 3'd0, ID_NONE, 3'd0, ID_NONE}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_GET, 31'd1, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_GET, 31'h7FFF_FFFF, 3'd0}, 1'b0, '0});
    dir_table.push_back('{1'b1, 8'hFF, '0, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_ADD, 31'd5, 3'd4}, 1'b0, '0});
    dir_table.push_back('{1'b0, 8'h00, '{OP_CLR_BAD, 31'd0, 3'd0}, 1'b1,
                          '{1'b1, ST_OK, 3'd0, ID_NONE, 3'd0, ID_NONE}});
    dir_table.push_back('{1'b0, 8'h00, '{OP_CLR_ALL, 31'd0, 3'd0}, 1'b1,
                          '{1'b1, ST_OK, 3'd0, ID_NONE, 3'd0, ID_NONE}});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) write_mask(dir_table[i].mask);
      else send_request(dir_table[i].req, 0, dir_table[i].typed, dir_table[i].exp);
    end

    // Random phases, each with its own mask and idling mix.
    phase_idle = '{0, 65, 17, 0, 65, 17};
    phase_mask = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h01, 8'h80,
                   8'($urandom_range(1, 254))};
    for (int p = 0; p < 6; p++) begin
      write_mask(phase_mask[p]);
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        ep_len = $urandom_range(10, 60);
        filling = ($urandom_range(3) == 0);
        if ($urandom_range(1) == 0) begin
          send_request('{OP_CLR_ALL, 31'($urandom), 3'($urandom_range(7))},
                       phase_idle[p], 1'b0, '0);
          sent++;
        end
        for (int k = 0; k < ep_len; k++) begin
          send_request(draw_request(filling), phase_idle[p], 1'b0, '0);
          sent++;
        end
      end
    end

    // Drain the outstanding results, then allow for any stray strobe.
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tidst_pkg.sv
rtl/tidst_ctrl.sv
rtl/tidst_dp.sv
rtl/tracked_id_state_table_top.sv
test/tb_tracked_id_state_table_top.sv
